// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// concurrent check that also holds during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/mrsa_pkg.sv =====
// ----------------------------------------------------------------------------
// mrsa_pkg
// Shared types and constants of the mixed-radix signed adder.
// ----------------------------------------------------------------------------
package mrsa_pkg;

  localparam int unsigned NUM_DIGITS = 4;
  localparam int unsigned DIGIT_W    = 32;
  localparam int unsigned IDX_W      = $clog2(NUM_DIGITS);

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [DIGIT_W:0]   wide_t;
  typedef logic [IDX_W-1:0]   reg_idx_t;

  // radix of each digit after reset, least significant first
  localparam digit_t RADIX_RESET [NUM_DIGITS] = '{32'd30, 32'd60, 32'd60, 32'd0};

endpackage

// ===== sv/mixed_radix_signed_adder_core.sv =====
// ----------------------------------------------------------------------------
// mixed_radix_signed_adder_core
// Sign-magnitude add of two mixed-radix numbers with signed compare, zero
// test and range flag; digit radices are writable registers.
// ----------------------------------------------------------------------------
//  channel   | handshake           | payload
//  ----------+---------------------+---------------------------------------
//  operands  | start, busy         | lhs_negative, lhs_digit0..3, rhs_*
//  result    | done (one cycle)    | sum_*, lhs_less, operands_equal,
//            |                     | sum_is_zero, bad_operand
//  config    | cfg_we              | cfg_index, cfg_data
//
//  One beat per clock while busy is low. Input register, then one pass of
//  per-digit carry-select add/subtract and carry mux chain into the result
//  register. busy is high only while rst is high; rst is synchronous and
//  clears the pipeline valids and loads the reset radices.
//  The result side has no stall: done marks each beat for one cycle.
// ----------------------------------------------------------------------------
module mixed_radix_signed_adder_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    lhs_negative,
  input  mrsa_pkg::digit_t        lhs_digit0,
  input  mrsa_pkg::digit_t        lhs_digit1,
  input  mrsa_pkg::digit_t        lhs_digit2,
  input  mrsa_pkg::digit_t        lhs_digit3,
  input  logic                    rhs_negative,
  input  mrsa_pkg::digit_t        rhs_digit0,
  input  mrsa_pkg::digit_t        rhs_digit1,
  input  mrsa_pkg::digit_t        rhs_digit2,
  input  mrsa_pkg::digit_t        rhs_digit3,
  output logic                    done,
  output logic                    sum_negative,
  output mrsa_pkg::digit_t        sum_digit0,
  output mrsa_pkg::digit_t        sum_digit1,
  output mrsa_pkg::digit_t        sum_digit2,
  output mrsa_pkg::digit_t        sum_digit3,
  output logic                    lhs_less,
  output logic                    operands_equal,
  output logic                    sum_is_zero,
  output logic                    bad_operand,
  input  logic                    cfg_we,
  input  mrsa_pkg::reg_idx_t      cfg_index,
  input  mrsa_pkg::digit_t        cfg_data
);

  localparam int unsigned N = mrsa_pkg::NUM_DIGITS;

  mrsa_pkg::digit_t radix [N];

  logic             accept;
  logic             v1;
  logic             an_q, bn_q;
  mrsa_pkg::digit_t a_q [N];
  mrsa_pkg::digit_t b_q [N];

  // per-digit terms, computed in parallel
  mrsa_pkg::wide_t  add_t0 [N];
  mrsa_pkg::wide_t  add_t1 [N];
  logic             add_c0 [N];
  logic             add_c1 [N];
  mrsa_pkg::digit_t add_s0 [N];
  mrsa_pkg::digit_t add_s1 [N];
  mrsa_pkg::digit_t big    [N];
  mrsa_pkg::digit_t little [N];
  mrsa_pkg::digit_t diff0  [N];
  mrsa_pkg::digit_t diff1  [N];
  logic             neg0   [N];
  logic             neg1   [N];
  mrsa_pkg::digit_t sub_s0 [N];
  mrsa_pkg::digit_t sub_s1 [N];
  mrsa_pkg::digit_t s_add  [N];
  mrsa_pkg::digit_t s_sub  [N];
  mrsa_pkg::digit_t s_next [N];

  logic carry, borrow;
  logic mag_lt, mag_gt, az, bz, bad;
  logic sn_next, less_next, equal_next, sz_next;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        radix[i] <= mrsa_pkg::RADIX_RESET[i];
      end
    end else if (cfg_we) begin
      radix[cfg_index] <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    if (accept) begin
      an_q    <= lhs_negative;
      bn_q    <= rhs_negative;
      a_q[0]  <= lhs_digit0;
      a_q[1]  <= lhs_digit1;
      a_q[2]  <= lhs_digit2;
      a_q[3]  <= lhs_digit3;
      b_q[0]  <= rhs_digit0;
      b_q[1]  <= rhs_digit1;
      b_q[2]  <= rhs_digit2;
      b_q[3]  <= rhs_digit3;
    end
  end

  // magnitude compare, zero tests and range flag
  always_comb begin
    mag_lt = 1'b0;
    mag_gt = 1'b0;
    az     = 1'b1;
    bz     = 1'b1;
    bad    = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (a_q[i] < b_q[i]) begin
        mag_lt = 1'b1;
        mag_gt = 1'b0;
      end else if (a_q[i] > b_q[i]) begin
        mag_lt = 1'b0;
        mag_gt = 1'b1;
      end
      if (a_q[i] != '0) az = 1'b0;
      if (b_q[i] != '0) bz = 1'b0;
      if (i < N - 1 || radix[i] != '0) begin
        if (radix[i] == '0 || a_q[i] >= radix[i] || b_q[i] >= radix[i]) bad = 1'b1;
      end
    end
  end

  // carry-select digit terms
  always_comb begin
    for (int i = 0; i < N; i++) begin
      add_t0[i] = {1'b0, a_q[i]} + {1'b0, b_q[i]};
      add_t1[i] = add_t0[i] + mrsa_pkg::wide_t'(1);
      add_c0[i] = (radix[i] != '0) && (add_t0[i] >= {1'b0, radix[i]});
      add_c1[i] = (radix[i] != '0) && (add_t1[i] >= {1'b0, radix[i]});
      add_s0[i] = add_c0[i] ? add_t0[i][mrsa_pkg::DIGIT_W-1:0] - radix[i]
                            : add_t0[i][mrsa_pkg::DIGIT_W-1:0];
      add_s1[i] = add_c1[i] ? add_t1[i][mrsa_pkg::DIGIT_W-1:0] - radix[i]
                            : add_t1[i][mrsa_pkg::DIGIT_W-1:0];

      big[i]    = mag_lt ? b_q[i] : a_q[i];
      little[i] = mag_lt ? a_q[i] : b_q[i];
      diff0[i]  = big[i] - little[i];
      diff1[i]  = diff0[i] - mrsa_pkg::digit_t'(1);
      neg0[i]   = big[i] < little[i];
      neg1[i]   = big[i] <= little[i];
      sub_s0[i] = neg0[i] ? diff0[i] + radix[i] : diff0[i];
      sub_s1[i] = neg1[i] ? diff1[i] + radix[i] : diff1[i];
    end
  end

  // carry / borrow select chain and result selection
  always_comb begin
    carry  = 1'b0;
    borrow = 1'b0;
    for (int i = 0; i < N; i++) begin
      s_add[i] = carry  ? add_s1[i] : add_s0[i];
      carry    = carry  ? add_c1[i] : add_c0[i];
      s_sub[i] = borrow ? sub_s1[i] : sub_s0[i];
      borrow   = borrow ? neg1[i]   : neg0[i];
    end

    equal_next = !mag_lt && !mag_gt && ((an_q == bn_q) || (az && bz));
    priority if (equal_next) less_next = 1'b0;
    else if (az)             less_next = !bn_q;
    else if (bz)             less_next = an_q;
    else if (an_q != bn_q)   less_next = an_q;
    else                     less_next = mag_lt ? !an_q : an_q;

    priority if (az) begin
      sn_next = bn_q;
      s_next  = b_q;
    end else if (bz) begin
      sn_next = an_q;
      s_next  = a_q;
    end else if (an_q == bn_q) begin
      sn_next = an_q;
      s_next  = s_add;
    end else begin
      sn_next = mag_lt ? bn_q : an_q;
      s_next  = s_sub;
    end

    sz_next = 1'b1;
    for (int i = 0; i < N; i++) begin
      if (s_next[i] != '0) sz_next = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v1;
    end
    if (v1) begin
      sum_negative   <= sn_next;
      sum_digit0     <= s_next[0];
      sum_digit1     <= s_next[1];
      sum_digit2     <= s_next[2];
      sum_digit3     <= s_next[3];
      lhs_less       <= less_next;
      operands_equal <= equal_next;
      sum_is_zero    <= sz_next;
      bad_operand    <= bad;
    end
  end

endmodule

// ===== sv/mrsa_checker.sv =====
// ----------------------------------------------------------------------------
// mrsa_checker
// Port-level checks on the adder core: beat timing and result consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrsa_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic             lhs_less,
  input logic             operands_equal,
  input logic             sum_is_zero,
  input mrsa_pkg::digit_t sum_digit0,
  input mrsa_pkg::digit_t sum_digit1,
  input mrsa_pkg::digit_t sum_digit2,
  input mrsa_pkg::digit_t sum_digit3
);

  logic sum_all_zero;

  assign sum_all_zero = (sum_digit0 == '0) && (sum_digit1 == '0) &&
                        (sum_digit2 == '0) && (sum_digit3 == '0);

  // every accepted beat gives a result through the input and result registers
  `ASSERT_CLK(a_beat_to_result, clk, rst, (start && !busy) |=> ##1 done, "result beat missing")

  // no result without an accepted beat ahead of it through the input and result registers
  `ASSERT_CLK(a_result_has_beat, clk, rst, done |-> $past(start && !busy, 2), "spurious result")

  // a strict less-than excludes equality
  `ASSERT_CLK(a_less_vs_equal, clk, rst, done |-> !(lhs_less && operands_equal), "less and equal")

  // zero flag agrees with the sum digits
  `ASSERT_CLK(a_zero_flag, clk, rst, done |-> (sum_is_zero == sum_all_zero), "zero flag mismatch")

endmodule

bind mixed_radix_signed_adder_core mrsa_checker u_mrsa_checker (.*);
